/* hdl/u16550_pkg.sv */
// Shared types and register codes of the 16550-style UART register block.
package u16550_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RX    = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [2:0] OFF_RBR = 3'd0;
  localparam logic [2:0] OFF_IER = 3'd1;
  localparam logic [2:0] OFF_IIR = 3'd2;
  localparam logic [2:0] OFF_LCR = 3'd3;
  localparam logic [2:0] OFF_MCR = 3'd4;
  localparam logic [2:0] OFF_LSR = 3'd5;
  localparam logic [2:0] OFF_MSR = 3'd6;
  localparam logic [2:0] OFF_SCR = 3'd7;

  localparam logic [7:0] IIR_RX_DATA  = 8'h04;
  localparam logic [7:0] IIR_THR_EMPT = 8'h02;
  localparam logic [7:0] IIR_NONE     = 8'h01;
  localparam logic [7:0] LSR_BASE     = 8'h60;
  localparam logic [7:0] IER_MASK     = 8'h0F;
  localparam logic [7:0] MCR_MASK     = 8'h1F;

  typedef struct packed {
    logic [7:0] rd;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
    logic       pop;
    logic       use_last;
  } result_t;

endpackage

/* hdl/u16550_ring_ram.sv */
// Receive ring storage: one write port and one registered read port.
module u16550_ring_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/uart_16550_register_model.sv */
// Top level of the 16550-style UART register block with its receive ring.
//
// Each bus read, bus write or received byte is one item on the slave stream, and each item
// gives one result on the master stream in the cycle after it is accepted. One item is accepted
// every cycle while the master side takes results; the rate is set by the single read port
// of the receive ring RAM, which is read at the tail pointer in the cycle an item enters and
// returns the byte with the result. Ring entries are undefined until written and the ring
// needs no clearing pass after reset. The ring holds at most RX_DEPTH-1 bytes; a byte that
// arrives at a full ring is dropped but still raises the interrupt request.
module uart_16550_register_model #(
  parameter int RX_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] reg_offset, [10:3] data_in, [15:11] zero
  input  logic [15:0] s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [15:8] tx_byte, [16] irq_request, [23:17] zero
  output logic [23:0] m_axis_tdata_o,
  // [0] tx_valid
  output logic        m_axis_tuser_o
);

  localparam int PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(RX_DEPTH - 1);

  logic [7:0]    lcr_q, lcr_d;
  logic [4:0]    mcr_q, mcr_d;
  logic [3:0]    ier_q, ier_d;
  logic [7:0]    dll_q, dll_d;
  logic [7:0]    dlm_q, dlm_d;
  logic [7:0]    scr_q, scr_d;
  logic [7:0]    last_q;
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic          dr_q, dr_d;
  logic          thr_q, thr_d;

  logic          out_valid_q;
  u16550_pkg::result_t res_q, res_d;

  logic          accept;
  logic [1:0]    cmd;
  logic [2:0]    off;
  logic [7:0]    din;
  logic          dlab;
  logic          empty;
  logic [PW-1:0] head_nxt;
  logic [PW-1:0] tail_nxt;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [7:0]    read_data;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd    = s_axis_tuser_i;
  assign off    = s_axis_tdata_i[2:0];
  assign din    = s_axis_tdata_i[10:3];
  assign dlab   = lcr_q[7];
  assign empty  = (head_q == tail_q);
  assign head_nxt = ptr_next(head_q);
  assign tail_nxt = ptr_next(tail_q);

  always_comb begin
    lcr_d  = lcr_q;
    mcr_d  = mcr_q;
    ier_d  = ier_q;
    dll_d  = dll_q;
    dlm_d  = dlm_q;
    scr_d  = scr_q;
    head_d = head_q;
    tail_d = tail_q;
    dr_d   = dr_q;
    thr_d  = thr_q;
    ram_we = 1'b0;
    res_d  = '0;
    case (cmd)
      u16550_pkg::CMD_READ: begin
        case (off)
          u16550_pkg::OFF_RBR: begin
            if (dlab) begin
              res_d.rd = dll_q;
            end else begin
              res_d.pop      = !empty;
              res_d.use_last = empty;
              tail_d         = empty ? tail_q : tail_nxt;
              dr_d           = (head_q != tail_d);
            end
          end
          u16550_pkg::OFF_IER: res_d.rd = dlab ? dlm_q : {4'd0, ier_q};
          u16550_pkg::OFF_IIR: begin
            if (dr_q && ier_q[0]) begin
              res_d.rd = u16550_pkg::IIR_RX_DATA;
            end else if (ier_q[1]) begin
              res_d.rd = u16550_pkg::IIR_THR_EMPT;
              thr_d    = 1'b0;
            end else begin
              res_d.rd = u16550_pkg::IIR_NONE;
            end
          end
          u16550_pkg::OFF_LCR: res_d.rd = lcr_q;
          u16550_pkg::OFF_MCR: res_d.rd = {3'd0, mcr_q};
          u16550_pkg::OFF_LSR: res_d.rd = u16550_pkg::LSR_BASE | {7'd0, dr_q};
          u16550_pkg::OFF_SCR: res_d.rd = scr_q;
          default:             res_d.rd = '0;
        endcase
      end
      u16550_pkg::CMD_WRITE: begin
        case (off)
          u16550_pkg::OFF_RBR: begin
            if (dlab) begin
              dll_d = din;
            end else begin
              res_d.tx_valid = 1'b1;
              res_d.tx_byte  = din;
              if (ier_q[1]) begin
                thr_d = 1'b1;
              end
            end
          end
          u16550_pkg::OFF_IER: begin
            if (dlab) begin
              dlm_d = din;
            end else begin
              ier_d = din[3:0] & u16550_pkg::IER_MASK[3:0];
              thr_d = din[1];
            end
          end
          u16550_pkg::OFF_LCR: lcr_d = din;
          u16550_pkg::OFF_MCR: mcr_d = din[4:0] & u16550_pkg::MCR_MASK[4:0];
          u16550_pkg::OFF_SCR: scr_d = din;
          default: ;
        endcase
        res_d.irq = thr_d || (dr_q && ier_d[0]);
      end
      u16550_pkg::CMD_RX: begin
        if (head_nxt != tail_q) begin
          ram_we = 1'b1;
          head_d = head_nxt;
          dr_d   = 1'b1;
        end
        res_d.irq = 1'b1;
      end
      default: ;
    endcase
  end

  u16550_ring_ram #(
    .DEPTH(RX_DEPTH),
    .AW   (PW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (accept && ram_we),
    .waddr_i(head_q),
    .wdata_i(din),
    .re_i   (accept),
    .raddr_i(tail_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcr_q       <= '0;
      mcr_q       <= '0;
      ier_q       <= '0;
      dll_q       <= '0;
      dlm_q       <= '0;
      scr_q       <= '0;
      last_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      dr_q        <= 1'b0;
      thr_q       <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (accept) begin
        lcr_q  <= lcr_d;
        mcr_q  <= mcr_d;
        ier_q  <= ier_d;
        dll_q  <= dll_d;
        dlm_q  <= dlm_d;
        scr_q  <= scr_d;
        head_q <= head_d;
        tail_q <= tail_d;
        dr_q   <= dr_d;
        thr_q  <= thr_d;
        res_q  <= res_d;
        if (res_q.pop) begin
          last_q <= ram_rdata;
        end
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign read_data = res_q.pop ? ram_rdata : (res_q.use_last ? last_q : res_q.rd);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, res_q.irq, res_q.tx_byte, read_data};
  assign m_axis_tuser_o  = res_q.tx_valid;

  a_ready_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dr_q == (head_q != tail_q))
    else $error("data ready flag disagrees with ring pointers");

  a_rx_irq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == u16550_pkg::CMD_RX) |=> m_axis_tvalid_o && m_axis_tdata_o[16])
    else $error("received byte did not raise the interrupt request");

  a_pop_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == u16550_pkg::CMD_READ) && (off == u16550_pkg::OFF_RBR) && !dlab && !empty
    |=> tail_q == ptr_next($past(tail_q)))
    else $error("tail pointer did not advance on a receive buffer read");

  a_tx_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("transmit result carries read data");

endmodule

/* tb/uart_16550_register_model_tb.sv */
// Self-checking stream testbench for the UART register block with its receive ring.
`timescale 1ns / 1ps

module uart_16550_register_model_tb;

  localparam int RX_DEPTH   = 256;
  localparam int CYCLE_CAP  = 200000;
  localparam int ITEM_COUNT = 900;

  typedef struct packed {
    u16550_pkg::cmd_e cmd;
    logic [2:0]       off;
    logic [7:0]       data;
  } uart_item_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq;
  } uart_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = u16550_pkg::CMD_NONE;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  uart_item_t  stim_q[$];
  uart_out_t   expected_q[$];
  logic        in_fire = 1'b0;
  int          err_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          sink_mode = 0;
  int          sink_left = 0;

  // predictor copy of the register file and receive ring
  logic [7:0]  lcr_q, dll_q, dlm_q, scr_q, last_rx_q;
  logic [4:0]  mcr_q;
  logic [3:0]  ier_q;
  logic [7:0]  rx_mem [RX_DEPTH];
  int unsigned head_q, tail_q;
  logic        dr_q, thre_q;

  uart_16550_register_model #(
    .RX_DEPTH(RX_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic uart_out_t uart_predict(input uart_item_t it);
    uart_out_t   r;
    logic        dlab;
    int unsigned nxt;
    r = '0;
    dlab = lcr_q[7];
    case (it.cmd)
      u16550_pkg::CMD_READ: begin
        case (it.off)
          u16550_pkg::OFF_RBR: begin
            if (dlab) begin
              r.rd = dll_q;
            end else begin
              if (head_q != tail_q) begin
                last_rx_q = rx_mem[tail_q];
                tail_q = (tail_q + 1) % RX_DEPTH;
              end
              dr_q = (head_q != tail_q);
              r.rd = last_rx_q;
            end
          end
          u16550_pkg::OFF_IER: r.rd = dlab ? dlm_q : {4'b0, ier_q};
          u16550_pkg::OFF_IIR: begin
            if (dr_q && ier_q[0]) begin
              r.rd = u16550_pkg::IIR_RX_DATA;
            end else if (ier_q[1]) begin
              thre_q = 1'b0;
              r.rd = u16550_pkg::IIR_THR_EMPT;
            end else begin
              r.rd = u16550_pkg::IIR_NONE;
            end
          end
          u16550_pkg::OFF_LCR: r.rd = lcr_q;
          u16550_pkg::OFF_MCR: r.rd = {3'b0, mcr_q};
          u16550_pkg::OFF_LSR: r.rd = u16550_pkg::LSR_BASE | {7'b0, dr_q};
          u16550_pkg::OFF_SCR: r.rd = scr_q;
          default: r.rd = '0;
        endcase
      end
      u16550_pkg::CMD_WRITE: begin
        case (it.off)
          u16550_pkg::OFF_RBR: begin
            if (dlab) begin
              dll_q = it.data;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = it.data;
              if (ier_q[1]) thre_q = 1'b1;
            end
          end
          u16550_pkg::OFF_IER: begin
            if (dlab) begin
              dlm_q = it.data;
            end else begin
              ier_q = it.data[3:0];
              thre_q = ier_q[1];
            end
          end
          u16550_pkg::OFF_LCR: lcr_q = it.data;
          u16550_pkg::OFF_MCR: mcr_q = it.data[4:0];
          u16550_pkg::OFF_SCR: scr_q = it.data;
          default: ;
        endcase
        r.irq = thre_q | (dr_q & ier_q[0]);
      end
      u16550_pkg::CMD_RX: begin
        nxt = (head_q + 1) % RX_DEPTH;
        if (nxt != tail_q) begin
          rx_mem[head_q] = it.data;
          head_q = nxt;
          dr_q = 1'b1;
        end
        r.irq = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_item(input u16550_pkg::cmd_e cmd, input logic [2:0] off,
                          input logic [7:0] data);
    uart_item_t it;
    it.cmd = cmd;
    it.off = off;
    it.data = data;
    stim_q.push_back(it);
  endtask

  always @(negedge clk_i) begin : drive
    uart_item_t nxt_item;
    logic       nxt_valid;
    if (rst_ni && (!s_axis_tvalid_i || in_fire)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (stim_q.size() > 0) begin
        nxt_item = stim_q.pop_front();
        nxt_valid = 1'b1;
        s_axis_tuser_i <= nxt_item.cmd;
        s_axis_tdata_i <= {5'b0, nxt_item.data, nxt_item.off};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 47);
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 14)
                                                 : $urandom_range(0, 3);
        end
      end
      s_axis_tvalid_i <= nxt_valid;
    end
  end

  always @(negedge clk_i) begin : sink
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_left = $urandom_range(20, 150);
    end
    sink_left--;
    case (sink_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 99) < 70);
      2: m_axis_tready_i <= ($urandom_range(0, 99) < 25);
      default: m_axis_tready_i <= ((sink_left % 5) < 2);
    endcase
  end

  always @(posedge clk_i) begin : observe
    uart_out_t got, want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.rd = m_axis_tdata_o[7:0];
        got.tx_valid = m_axis_tuser_o;
        got.tx_byte = m_axis_tdata_o[15:8];
        got.irq = m_axis_tdata_o[16];
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, got);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.rd !== want.rd) begin
            $display("%0t read_data expected %02h got %02h", $time, want.rd, got.rd);
            err_count++;
          end
          if (got.tx_valid !== want.tx_valid) begin
            $display("%0t tx_valid expected %0b got %0b", $time, want.tx_valid, got.tx_valid);
            err_count++;
          end
          if (got.tx_byte !== want.tx_byte) begin
            $display("%0t tx_byte expected %02h got %02h", $time, want.tx_byte, got.tx_byte);
            err_count++;
          end
          if (got.irq !== want.irq) begin
            $display("%0t irq_request expected %0b got %0b", $time, want.irq, got.irq);
            err_count++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_q.push_back(uart_predict({u16550_pkg::cmd_e'(s_axis_tuser_i),
                                           s_axis_tdata_i[2:0], s_axis_tdata_i[10:3]}));
      end
      in_fire <= s_axis_tvalid_i && s_axis_tready_o;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int               made;
    int               n;
    int               pick;
    bit               filled;
    u16550_pkg::cmd_e c;
    lcr_q = '0;
    dll_q = '0;
    dlm_q = '0;
    scr_q = '0;
    last_rx_q = '0;
    mcr_q = '0;
    ier_q = '0;
    head_q = 0;
    tail_q = 0;
    dr_q = 1'b0;
    thre_q = 1'b0;
    made = 0;
    filled = 1'b0;

    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IIR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_LSR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_MSR, 8'h00);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_IER, 8'hFF);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IER, 8'h00);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_RBR, 8'hA5);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IIR, 8'h00);
    add_item(u16550_pkg::CMD_RX, u16550_pkg::OFF_RBR, 8'h00);
    add_item(u16550_pkg::CMD_RX, u16550_pkg::OFF_SCR, 8'hFF);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IIR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_LSR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'h00);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'h00);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LCR, 8'h80);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_RBR, 8'h12);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_IER, 8'h34);
    add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'h00);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LCR, 8'h03);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_MCR, 8'hFF);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_SCR, 8'h5A);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_IIR, 8'hC7);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LSR, 8'hFF);
    add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_MSR, 8'hFF);
    add_item(u16550_pkg::CMD_NONE, 3'd7, 8'hFF);

    while (made < ITEM_COUNT) begin
      pick = $urandom_range(0, 99);
      if (!filled && made > 250) begin
        filled = 1'b1;
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LCR, 8'h03);
        for (int i = 0; i < RX_DEPTH + 2; i++) begin
          add_item(u16550_pkg::CMD_RX, 3'($urandom), 8'($urandom));
        end
        add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_LSR, 8'h00);
        for (int i = 0; i < RX_DEPTH + 2; i++) begin
          add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'($urandom));
        end
        made += 2 * RX_DEPTH + 6;
      end else if (pick < 45) begin
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          pick = $urandom_range(0, 99);
          c = (pick < 40) ? u16550_pkg::CMD_READ :
              (pick < 70) ? u16550_pkg::CMD_WRITE :
              (pick < 95) ? u16550_pkg::CMD_RX : u16550_pkg::CMD_NONE;
          add_item(c, 3'($urandom), 8'($urandom));
          if (c != u16550_pkg::CMD_NONE) made++;
        end
      end else if (pick < 70) begin
        n = $urandom_range(1, 8);
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LCR, 8'($urandom) & 8'h7F);
        for (int i = 0; i < n; i++) add_item(u16550_pkg::CMD_RX, 3'($urandom), 8'($urandom));
        for (int i = 0; i <= n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            add_item(u16550_pkg::CMD_READ,
                     ($urandom_range(0, 1) ? u16550_pkg::OFF_IIR : u16550_pkg::OFF_LSR),
                     8'h00);
          end
          add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'($urandom));
        end
        made += 2 * n + 2;
      end else if (pick < 88) begin
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_IER, 8'($urandom));
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_RBR, 8'($urandom));
        end
        add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IIR, 8'($urandom));
        add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IIR, 8'($urandom));
        made += n + 3;
      end else begin
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LCR, 8'($urandom) | 8'h80);
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_RBR, 8'($urandom));
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_IER, 8'($urandom));
        add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_RBR, 8'($urandom));
        add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_IER, 8'($urandom));
        add_item(u16550_pkg::CMD_READ, u16550_pkg::OFF_LCR, 8'($urandom));
        add_item(u16550_pkg::CMD_WRITE, u16550_pkg::OFF_LCR, 8'($urandom) & 8'h7F);
        made += 7;
      end
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    while (stim_q.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
